FILE: src/box_overlap_test_aabb_obb_macros.svh
// Assertion macros shared by the box overlap checker.
`ifndef BOX_OVERLAP_TEST_AABB_OBB_MACROS_SVH
`define BOX_OVERLAP_TEST_AABB_OBB_MACROS_SVH

// Same-cycle implication, sampled on the rising clock edge.
`define BOXOV_ASSERT_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on the rising clock edge.
`define BOXOV_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: src/boxov_pkg.sv
// Shared types, constants and helper functions of the box overlap tester.
package boxov_pkg;

	typedef logic [2:0] axis_t;
	typedef logic signed [31:0] word_t;

	localparam int WORD_W        = 32;
	localparam int WORDS_PER_BOX = 18;
	localparam int NUM_WORDS     = 2 * WORDS_PER_BOX;
	localparam int ADDR_W        = $clog2(NUM_WORDS);

	// Word layout inside one box.
	localparam int W_MAX0 = 3;
	localparam int W_MAT  = 6;
	localparam int W_ROW4 = 15;
	localparam int W_M11  = 6;
	localparam int W_M22  = 10;
	localparam int W_M33  = 14;

	// Command and test codes.
	localparam logic ACT_WRITE = 1'b0;
	localparam logic ACT_RUN   = 1'b1;
	localparam logic KIND_AABB = 1'b0;
	localparam logic KIND_OBB  = 1'b1;

	localparam axis_t AXIS_NONE = 3'd6;

	// Corner selection per oriented job: bit k set takes the max coordinate.
	localparam logic [2:0] PMASK [8] = '{3'b000, 3'b111, 3'b110, 3'b101,
		3'b011, 3'b001, 3'b010, 3'b100};

	// Clamp a wide signed value into 32 signed bits.
	function automatic word_t sat32(input logic signed [63:0] v);
		if (v > 64'sd2147483647) begin
			return 32'sh7fffffff;
		end else if (v < -64'sd2147483648) begin
			return 32'sh80000000;
		end
		return v[31:0];
	endfunction

	// Absolute value of a 64-bit signed value.
	function automatic logic signed [63:0] abs64(input logic signed [63:0] v);
		return v[63] ? -v : v;
	endfunction

endpackage

FILE: src/boxov_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module boxov_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 36
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write port and registered read port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

FILE: src/boxov_sqrt.sv
// Iterative integer square root, two radicand bits per cycle.
module boxov_sqrt (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [63:0] val,
	output logic        done,
	output logic [31:0] root
);

	logic        busy_q;
	logic [63:0] v_q;
	logic [63:0] res_q;
	logic [63:0] bit_q;
	logic [63:0] trial;

	assign trial = res_q + bit_q;
	assign done  = busy_q && (bit_q == '0);
	assign root  = res_q[31:0];

	// Busy flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
		end else if (start) begin
			busy_q <= 1'b1;
		end else if (done) begin
			busy_q <= 1'b0;
		end
	end

	// One digit of the root per cycle.
	always_ff @(posedge clk) begin
		if (start) begin
			v_q   <= val;
			res_q <= '0;
			bit_q <= 64'd1 << 62;
		end else if (busy_q && (bit_q != '0)) begin
			if (v_q >= trial) begin
				v_q   <= v_q - trial;
				res_q <= (res_q >> 1) + bit_q;
			end else begin
				res_q <= res_q >> 1;
			end
			bit_q <= bit_q >> 2;
		end
	end

endmodule

FILE: src/boxov_div.sv
// Restoring divider, one quotient bit per cycle, 32-bit divisor.
module boxov_div #(
	parameter int DVD_W = 48
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [DVD_W-1:0] dividend,
	input  logic [31:0]      divisor,
	output logic             done,
	output logic [DVD_W-1:0] quot
);

	localparam int CNT_W = $clog2(DVD_W + 1);

	logic             busy_q;
	logic [CNT_W-1:0] cnt_q;
	logic [DVD_W-1:0] dvd_q;
	logic [32:0]      rem_q;
	logic [31:0]      div_q;
	logic [32:0]      rem_n;
	logic             ge;

	assign rem_n = {rem_q[31:0], dvd_q[DVD_W-1]};
	assign ge    = rem_n >= {1'b0, div_q};
	assign done  = busy_q && (cnt_q == '0);
	assign quot  = dvd_q;

	// Step counter and busy flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= CNT_W'(DVD_W);
		end else if (done) begin
			busy_q <= 1'b0;
		end else if (busy_q) begin
			cnt_q <= cnt_q - 1'b1;
		end
	end

	// Shift the dividend out and the quotient in.
	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= dividend;
			div_q <= divisor;
			rem_q <= '0;
		end else if (busy_q && (cnt_q != '0)) begin
			rem_q <= ge ? (rem_n - {1'b0, div_q}) : rem_n;
			dvd_q <= {dvd_q[DVD_W-2:0], ge};
		end
	end

endmodule

FILE: src/box_overlap_test_aabb_obb.sv
// Box overlap tester: two stored boxes, axis-aligned or oriented separating-axis test.
//
// Command channel (cmd_valid/cmd_stall): a word with action write loads one box
// word (box_sel, word_index 0-17, word_value); indexes 18-31 are dropped. A word
// with action run starts a test chosen by test_kind and gives one result word.
// Result channel (res_valid/res_stall): overlap, separating_axis, hit_mark.
// A write gives no result. A run holds cmd_stall high until its result is in
// the output register. The box words live in a 36-word RAM; each test reloads
// a box through its single read port and walks all products through one shared
// multiplier. An oriented run takes longer than an axis-aligned one, mostly in
// the bit-serial divider (one division for each of 18 axis components) and the
// square-root unit; zero-length axes skip their divisions.
// Reset: all words read as zero bounds and identity matrices (per-word valid
// bits, no clearing pass), the hit mark is cleared, no result is pending.
// A stalled result holds; a finished run waits for the output register to free.
module box_overlap_test_aabb_obb #(
	parameter int FRAC_BITS = 16
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cmd_valid,
	output logic                      cmd_stall,
	input  logic                      action,
	input  logic                      box_sel,
	input  logic [4:0]                word_index,
	input  logic signed [31:0]        word_value,
	input  logic                      test_kind,
	input  logic                      mark_on_hit,
	output logic                      res_valid,
	input  logic                      res_stall,
	output logic                      overlap,
	output boxov_pkg::axis_t          separating_axis,
	output logic                      hit_mark
);

	import boxov_pkg::*;

	localparam int AX_W  = FRAC_BITS + 2;
	localparam int Q_W   = FRAC_BITS + 1;
	localparam int DVD_W = WORD_W + FRAC_BITS;
	localparam word_t FIX_ONE = word_t'(64'sd1 <<< FRAC_BITS);

	localparam logic [2:0] JOB_CTR  = 3'd0;
	localparam logic [2:0] JOB_P5   = 3'd1;
	localparam logic [2:0] JOB_AX0  = 3'd2;
	localparam logic [2:0] JOB_AX2  = 3'd4;
	localparam logic [2:0] JOB_EXT0 = 3'd5;
	localparam logic [2:0] JOB_LAST = 3'd7;

	typedef enum logic [3:0] {
		S_IDLE, S_LOAD, S_XMUL, S_XACC, S_JOB, S_SQMUL, S_SQACC, S_ROOTGO,
		S_ROOTW, S_DIVGO, S_DIVW, S_PMUL, S_PACC, S_CMP, S_DONE
	} state_t;

	// Control state.
	state_t              st_q;
	logic                b_q;
	logic [2:0]          job_q;
	logic [1:0]          k_q;
	logic [1:0]          c_q;
	logic [4:0]          li_q;
	logic [2:0]          i_q;
	logic [2:0]          t_q;
	logic                kind_q;
	logic                mark_in_q;
	logic                hit_q;
	axis_t               sepw_q;
	logic [NUM_WORDS-1:0] vld_q;
	logic                res_valid_q;
	logic                overlap_q;
	axis_t               sep_q;
	logic                hit_out_q;

	// Working data.
	word_t                  mn_q [3];
	word_t                  mx_q [3];
	word_t                  mat_q [9];
	word_t                  row4_q [3];
	word_t                  tp_q [3];
	word_t                  p5_q [3];
	word_t                  ctra_q [3];
	word_t                  ctrb_q [3];
	word_t                  lo_q [2][3];
	word_t                  hi_q [2][3];
	word_t                  dd_q [3];
	word_t                  ext_q [18];
	logic signed [AX_W-1:0] ax_q [18];
	logic signed [63:0]     acc_q;
	logic signed [63:0]     prod_q;
	logic signed [63:0]     r_q;
	logic [ADDR_W-1:0]      rd_addr_s1;
	logic [31:0]            len_q;

	// RAM and unit hookup.
	logic              ram_we;
	logic [ADDR_W-1:0] ram_waddr;
	logic              ram_re;
	logic [ADDR_W-1:0] rd_addr;
	logic [WORD_W-1:0] ram_rdata;
	logic              root_done;
	logic [31:0]       root_res;
	logic              div_done;
	logic [DVD_W-1:0]  div_quot;

	// Combinational helpers.
	logic               cmd_acc;
	logic [4:0]         wi;
	word_t              rword;
	logic [2:0]         msk;
	logic               ctr_pt;
	word_t              hk;
	word_t              xk;
	logic [3:0]         mat_idx;
	logic [4:0]         ext_rd_idx;
	logic [4:0]         ax_rd_idx;
	logic [4:0]         ax_base;
	logic [4:0]         ext_base;
	logic [1:0]         aj;
	logic signed [32:0] dv_c;
	logic signed [32:0] ma;
	logic signed [32:0] mb;
	logic signed [65:0] prod_full;
	logic signed [63:0] xsum;
	logic signed [63:0] psum;
	logic signed [63:0] pval;
	logic [31:0]        dmag;
	logic [Q_W-1:0]     qv;
	logic signed [AX_W-1:0] axv;
	logic               axis_job;
	logic               last_job;
	logic               do_adv;
	axis_t              aabb_sep;
	logic               new_hit;

	assign cmd_acc         = cmd_valid && !cmd_stall;
	assign cmd_stall       = (st_q != S_IDLE);
	assign res_valid       = res_valid_q;
	assign overlap         = overlap_q;
	assign separating_axis = sep_q;
	assign hit_mark        = hit_out_q;

	// Box word store; writes only arrive while idle, so no read can collide.
	assign ram_we    = cmd_acc && (action == ACT_WRITE) &&
		(word_index < 5'(WORDS_PER_BOX));
	assign ram_waddr = (box_sel ? ADDR_W'(WORDS_PER_BOX) : '0) + ADDR_W'(word_index);
	assign ram_re    = (st_q == S_LOAD) && (li_q < 5'(WORDS_PER_BOX));
	assign rd_addr   = (b_q ? ADDR_W'(WORDS_PER_BOX) : '0) + ADDR_W'(li_q);

	boxov_ram #(
		.WIDTH (WORD_W),
		.DEPTH (NUM_WORDS)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (word_value),
		.re    (ram_re),
		.raddr (rd_addr),
		.rdata (ram_rdata)
	);

	// A never-written word reads as its reset value.
	assign wi    = li_q - 5'd1;
	assign rword = vld_q[rd_addr_s1] ? word_t'(ram_rdata) :
		((wi == 5'(W_M11) || wi == 5'(W_M22) || wi == 5'(W_M33)) ? FIX_ONE : '0);

	// Transform operand: a corner coordinate or the floored box center.
	assign msk     = kind_q ? PMASK[job_q] : {3{job_q[0]}};
	assign ctr_pt  = kind_q && (job_q == JOB_CTR);
	assign hk      = word_t'((33'(mn_q[k_q]) + 33'(mx_q[k_q])) >>> 1);
	assign xk      = ctr_pt ? hk : (msk[k_q] ? mx_q[k_q] : mn_q[k_q]);
	assign mat_idx = 4'(k_q) * 4'd3 + 4'(c_q);

	// Projection operands.
	assign ext_rd_idx = (t_q == 3'd6) ? 5'd0 : (5'(t_q) * 5'd3 + 5'(c_q));
	assign ax_rd_idx  = 5'(i_q) * 5'd3 + 5'(c_q);
	assign dv_c       = 33'(ctrb_q[c_q]) - 33'(ctra_q[c_q]);

	// Axis and extent write positions for the current box and job.
	assign aj       = 2'(job_q - JOB_AX0);
	assign ax_base  = (5'(b_q) * 5'd3 + 5'(aj)) * 5'd3;
	assign ext_base = 5'(b_q) * 5'd9 + 5'(job_q - JOB_EXT0) * 5'd3;

	// Shared multiplier operand selection.
	always_comb begin
		ma = '0;
		mb = '0;
		unique case (st_q)
			S_XMUL: begin
				ma = 33'(xk);
				mb = 33'(mat_q[mat_idx]);
			end
			S_SQMUL: begin
				ma = 33'(dd_q[c_q]);
				mb = 33'(dd_q[c_q]);
			end
			S_PMUL: begin
				ma = (t_q == 3'd6) ? dv_c : 33'(ext_q[ext_rd_idx]);
				mb = 33'(ax_q[ax_rd_idx]);
			end
			default: begin
				ma = '0;
				mb = '0;
			end
		endcase
	end

	assign prod_full = ma * mb;

	// Accumulation paths.
	assign xsum = ((k_q == 2'd0) ? 64'(row4_q[c_q]) : acc_q) + (prod_q >>> FRAC_BITS);
	assign psum = ((c_q == 2'd0) ? 64'sd0 : acc_q) + prod_q;
	assign pval = abs64(psum >>> FRAC_BITS);

	// Division operands and signed axis component.
	assign dmag = dd_q[c_q][31] ? (~dd_q[c_q] + 32'd1) : dd_q[c_q];
	assign qv   = div_quot[Q_W-1:0];
	assign axv  = dd_q[c_q][31] ? -$signed({1'b0, qv}) : $signed({1'b0, qv});

	boxov_sqrt u_sqrt (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (st_q == S_ROOTGO),
		.val    (acc_q),
		.done   (root_done),
		.root   (root_res)
	);

	boxov_div #(
		.DVD_W (DVD_W)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (st_q == S_DIVGO),
		.dividend ({dmag, FRAC_BITS'(0)}),
		.divisor  (len_q),
		.done     (div_done),
		.quot     (div_quot)
	);

	// Job sequencing.
	assign axis_job = kind_q && (job_q >= JOB_AX0) && (job_q <= JOB_AX2);
	assign last_job = kind_q ? (job_q == JOB_LAST) : (job_q == JOB_P5);
	assign do_adv   = ((st_q == S_JOB) && !axis_job) ||
		((st_q == S_ROOTW) && root_done && (root_res == '0)) ||
		((st_q == S_DIVW) && div_done && (c_q == 2'd2));

	// First axis on which the transformed intervals do not meet.
	always_comb begin
		aabb_sep = AXIS_NONE;
		for (int n = 2; n >= 0; n--) begin
			if (((lo_q[0][n] > lo_q[1][n]) ? lo_q[0][n] : lo_q[1][n]) >
				((hi_q[0][n] < hi_q[1][n]) ? hi_q[0][n] : hi_q[1][n])) begin
				aabb_sep = axis_t'(n);
			end
		end
	end

	assign new_hit = (kind_q == KIND_OBB) ? ((sepw_q == AXIS_NONE) ? mark_in_q : 1'b0) :
		hit_q;

	// Sequencer state, valid bits and the result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q        <= S_IDLE;
			b_q         <= 1'b0;
			job_q       <= '0;
			k_q         <= '0;
			c_q         <= '0;
			li_q        <= '0;
			i_q         <= '0;
			t_q         <= '0;
			kind_q      <= KIND_AABB;
			mark_in_q   <= 1'b0;
			hit_q       <= 1'b0;
			sepw_q      <= AXIS_NONE;
			vld_q       <= '0;
			res_valid_q <= 1'b0;
			overlap_q   <= 1'b0;
			sep_q       <= AXIS_NONE;
			hit_out_q   <= 1'b0;
		end else begin
			if (ram_we) begin
				vld_q[ram_waddr] <= 1'b1;
			end
			if (res_valid_q && !res_stall && (st_q != S_DONE)) begin
				res_valid_q <= 1'b0;
			end
			unique case (st_q)
				S_IDLE: begin
					if (cmd_acc && (action == ACT_RUN)) begin
						kind_q    <= test_kind;
						mark_in_q <= mark_on_hit;
						b_q       <= 1'b0;
						li_q      <= '0;
						job_q     <= JOB_CTR;
						st_q      <= S_LOAD;
					end
				end
				S_LOAD: begin
					if (li_q == 5'(WORDS_PER_BOX)) begin
						k_q  <= '0;
						c_q  <= '0;
						st_q <= S_XMUL;
					end else begin
						li_q <= li_q + 5'd1;
					end
				end
				S_XMUL: st_q <= S_XACC;
				S_XACC: begin
					if (k_q != 2'd2) begin
						k_q  <= k_q + 2'd1;
						st_q <= S_XMUL;
					end else begin
						k_q <= '0;
						if (c_q != 2'd2) begin
							c_q  <= c_q + 2'd1;
							st_q <= S_XMUL;
						end else begin
							c_q  <= '0;
							st_q <= S_JOB;
						end
					end
				end
				S_JOB: begin
					if (axis_job) begin
						c_q  <= '0;
						st_q <= S_SQMUL;
					end
				end
				S_SQMUL: st_q <= S_SQACC;
				S_SQACC: begin
					if (c_q != 2'd2) begin
						c_q  <= c_q + 2'd1;
						st_q <= S_SQMUL;
					end else begin
						c_q  <= '0;
						st_q <= S_ROOTGO;
					end
				end
				S_ROOTGO: st_q <= S_ROOTW;
				S_ROOTW: begin
					if (root_done && (root_res != '0)) begin
						c_q  <= '0;
						st_q <= S_DIVGO;
					end
				end
				S_DIVGO: st_q <= S_DIVW;
				S_DIVW: begin
					if (div_done && (c_q != 2'd2)) begin
						c_q  <= c_q + 2'd1;
						st_q <= S_DIVGO;
					end
				end
				S_PMUL: st_q <= S_PACC;
				S_PACC: begin
					if (c_q != 2'd2) begin
						c_q  <= c_q + 2'd1;
						st_q <= S_PMUL;
					end else begin
						c_q <= '0;
						if (t_q != 3'd6) begin
							t_q  <= t_q + 3'd1;
							st_q <= S_PMUL;
						end else if (r_q < pval) begin
							sepw_q <= axis_t'(i_q);
							st_q   <= S_DONE;
						end else if (i_q == 3'd5) begin
							sepw_q <= AXIS_NONE;
							st_q   <= S_DONE;
						end else begin
							i_q  <= i_q + 3'd1;
							t_q  <= '0;
							st_q <= S_PMUL;
						end
					end
				end
				S_CMP: begin
					sepw_q <= aabb_sep;
					st_q   <= S_DONE;
				end
				S_DONE: begin
					if (!res_valid_q || !res_stall) begin
						res_valid_q <= 1'b1;
						overlap_q   <= (sepw_q == AXIS_NONE);
						sep_q       <= sepw_q;
						hit_q       <= new_hit;
						hit_out_q   <= new_hit;
						st_q        <= S_IDLE;
					end
				end
				default: st_q <= S_IDLE;
			endcase
			// Move to the next point, the next box or the final test.
			if (do_adv) begin
				if (!last_job) begin
					job_q <= job_q + 3'd1;
					k_q   <= '0;
					c_q   <= '0;
					st_q  <= S_XMUL;
				end else if (!b_q) begin
					b_q   <= 1'b1;
					li_q  <= '0;
					job_q <= JOB_CTR;
					st_q  <= S_LOAD;
				end else if (kind_q == KIND_OBB) begin
					i_q  <= '0;
					t_q  <= '0;
					c_q  <= '0;
					st_q <= S_PMUL;
				end else begin
					st_q <= S_CMP;
				end
			end
		end
	end

	// Datapath registers.
	always_ff @(posedge clk) begin
		prod_q     <= prod_full[63:0];
		rd_addr_s1 <= rd_addr;
		if (st_q == S_LOAD) begin
			r_q <= '0;
		end
		unique case (st_q)
			S_LOAD: begin
				if (li_q != '0) begin
					if (wi < 5'(W_MAX0)) begin
						mn_q[wi[1:0]] <= rword;
					end else if (wi < 5'(W_MAT)) begin
						mx_q[2'(wi - 5'(W_MAX0))] <= rword;
					end else if (wi < 5'(W_ROW4)) begin
						mat_q[4'(wi - 5'(W_MAT))] <= rword;
					end else begin
						row4_q[2'(wi - 5'(W_ROW4))] <= rword;
					end
				end
			end
			S_XACC: begin
				acc_q <= xsum;
				if (k_q == 2'd2) begin
					tp_q[c_q] <= sat32(xsum);
				end
			end
			S_JOB: begin
				if (kind_q == KIND_AABB) begin
					for (int n = 0; n < 3; n++) begin
						if (job_q[0]) begin
							hi_q[b_q][n] <= tp_q[n];
						end else begin
							lo_q[b_q][n] <= tp_q[n];
						end
					end
				end else if (job_q == JOB_CTR) begin
					for (int n = 0; n < 3; n++) begin
						if (b_q) begin
							ctrb_q[n] <= tp_q[n];
						end else begin
							ctra_q[n] <= tp_q[n];
						end
					end
				end else if (job_q == JOB_P5) begin
					for (int n = 0; n < 3; n++) begin
						p5_q[n] <= tp_q[n];
					end
				end else if (axis_job) begin
					for (int n = 0; n < 3; n++) begin
						dd_q[n] <= sat32(64'(p5_q[n]) - 64'(tp_q[n]));
					end
				end else begin
					// Half extent: corner midpoint relative to the center.
					for (int n = 0; n < 3; n++) begin
						ext_q[ext_base + 5'(n)] <= sat32(((64'(p5_q[n]) + 64'(tp_q[n])) >>> 1) -
							64'(b_q ? ctrb_q[n] : ctra_q[n]));
					end
				end
			end
			S_SQACC: acc_q <= psum;
			S_ROOTW: begin
				if (root_done) begin
					len_q <= root_res;
					if (root_res == '0) begin
						for (int n = 0; n < 3; n++) begin
							ax_q[ax_base + 5'(n)] <= '0;
						end
					end
				end
			end
			S_DIVW: begin
				if (div_done) begin
					ax_q[ax_base + 5'(c_q)] <= axv;
				end
			end
			S_PACC: begin
				acc_q <= psum;
				if (c_q == 2'd2) begin
					if (t_q != 3'd6) begin
						r_q <= r_q + pval;
					end else begin
						r_q <= '0;
					end
				end
			end
			default: begin
			end
		endcase
	end

endmodule

FILE: src/boxov_chk.sv
// Port-level checker for the box overlap tester, bound to the top level.
`include "box_overlap_test_aabb_obb_macros.svh"

module boxov_chk (
	input logic             clk,
	input logic             arst_n,
	input logic             cmd_valid,
	input logic             cmd_stall,
	input logic             action,
	input logic             res_valid,
	input logic             res_stall,
	input logic             overlap,
	input boxov_pkg::axis_t separating_axis
);

	import boxov_pkg::*;

	// A result word that is not taken stays offered.
	`BOXOV_ASSERT_NEXT(a_res_hold, res_valid && res_stall, res_valid, "result dropped while stalled")

	// A run keeps the command side stalled while it works.
	`BOXOV_ASSERT_NEXT(a_run_busy, cmd_valid && !cmd_stall && (action == ACT_RUN), cmd_stall, "run did not stall commands")

	// A write never produces a result word.
	`BOXOV_ASSERT_NEXT(a_write_quiet, cmd_valid && !cmd_stall && (action == ACT_WRITE) && !res_valid, !res_valid, "write produced a result")

	// The overlap flag agrees with the reported axis.
	`BOXOV_ASSERT_SAME(a_overlap_axis, res_valid, overlap == (separating_axis == AXIS_NONE), "overlap and axis disagree")

endmodule

bind box_overlap_test_aabb_obb boxov_chk u_boxov_chk (.*);
